// ----- hw/rtl/sfla_pkg.sv -----
// Package with constants, types and helper functions of the free-list allocator.
`timescale 1ns / 1ps
package sfla_pkg;

	localparam int HEAP_WORDS   = 16384;
	localparam int CHUNK_BYTES  = 4096;
	localparam int SIZE_CLASSES = 10;

	localparam int HEAP_BYTES = HEAP_WORDS * 4;
	localparam int ADDR_W     = $clog2(HEAP_WORDS);
	localparam int STEP_W     = $clog2(HEAP_WORDS + 1);
	localparam int CLS_W      = $clog2(SIZE_CLASSES + 1);
	localparam int BRK_W      = $clog2(HEAP_BYTES + 1);
	localparam int WORD_W     = 32;

	// Byte offset of the last class head; the prologue words follow it.
	localparam logic [31:0] BASE_OFF = 32'(4 * SIZE_CLASSES);

	typedef enum logic [1:0] {
		ACT_INIT    = 2'd0,
		ACT_ALLOC   = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_RESIZE  = 2'd3
	} action_t;

	// One request as the sequencer sees it.
	typedef struct packed {
		action_t     action;
		logic [15:0] request_size;
		logic [15:0] block_offset;
		logic        block_is_null;
	} cmd_t;

	// One finished result.
	typedef struct packed {
		logic [15:0] result_offset;
		logic        result_null;
	} rslt_t;

	// Sequencer status toward the channel logic.
	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	// Heap memory access of one cycle.
	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] ra;
		logic              we;
		logic [ADDR_W-1:0] wa;
		logic [WORD_W-1:0] wd;
	} mem_req_t;

	// Size field of a header or footer word.
	function automatic logic [31:0] sz(input logic [31:0] v);
		return v & ~32'd7;
	endfunction

	// True when a byte address falls inside the heap store.
	function automatic logic in_heap(input logic [31:0] a);
		return a[31:2] < 30'(HEAP_WORDS);
	endfunction

	// Size class: the first class whose limit exceeds the size, else the last.
	function automatic logic [CLS_W-1:0] class_of(input logic [31:0] s);
		logic [CLS_W-1:0] c;
		c = CLS_W'(SIZE_CLASSES - 1);
		for (int i = SIZE_CLASSES - 2; i >= 0; i--) begin
			if (s < (32'd1 << (i + 5)))
				c = CLS_W'(i);
		end
		return c;
	endfunction

	// Byte offset of a class list head.
	function automatic logic [31:0] head_addr(input logic [CLS_W-1:0] c);
		return 32'd4 + {{(30 - CLS_W){1'b0}}, c, 2'b00};
	endfunction

	// Heap growth in bytes, rounded to an even word count.
	function automatic logic [31:0] grow_size(input logic [31:0] b);
		logic [31:0] w;
		w = {2'b00, b[31:2]};
		w = w + {31'd0, w[0]};
		return {w[29:0], 2'b00};
	endfunction

endpackage

// ----- hw/rtl/sfla_if.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface sfla_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] request_size;
	logic [15:0] block_offset;
	logic        block_is_null;

	modport source (output valid, action, request_size, block_offset, block_is_null,
		input ready);
	modport sink (input valid, action, request_size, block_offset, block_is_null,
		output ready);
endinterface

interface sfla_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_offset;
	logic        result_null;

	modport source (output valid, result_offset, result_null, input ready);
	modport sink (input valid, result_offset, result_null, output ready);
endinterface

// ----- hw/rtl/segregated_free_list_allocator_top.sv -----
// Top level of the segregated free-list heap allocator.
// Usage:
// - Requests arrive as beats on the req channel (action, request_size, block_offset,
//   block_is_null); each request gives exactly one beat on the rsp channel.
// - One request is worked on at a time. req.ready is high while the sequencer is idle,
//   also while a finished result still waits in the rsp output register.
// - Every heap access goes through one 16384 x 32 RAM with one read and one write
//   port; read data is registered, and the time a request takes depends on the data:
//   each free-list entry visited, each empty class skipped, a heap growth and each
//   payload word copied by resize add to it.
// - Before the first init, allocate, release and resize answer null at once.
// - Reset clears the break and the control state; heap words are left as they are
//   and are rebuilt by init. No clearing pass is run.
// - When the receiver stalls, the result stays in the output register; a following
//   result waits in the sequencer until the register is free.
`timescale 1ns / 1ps
module segregated_free_list_allocator_top (
	input logic        clk,
	input logic        arst_n,
	sfla_req_if.sink   req,
	sfla_rsp_if.source rsp
);
	import sfla_pkg::*;

	cmd_t              cmd;
	seq_stat_t         stat;
	rslt_t             rslt;
	mem_req_t          mem;
	logic [WORD_W-1:0] rdata;
	logic              start, ack, rsp_valid_q;
	rslt_t             rsp_q;

	// Request beat enters the sequencer only when it is idle.
	assign req.ready = stat.idle;
	assign start     = req.valid && stat.idle;
	assign cmd.action        = action_t'(req.action);
	assign cmd.request_size  = req.request_size;
	assign cmd.block_offset  = req.block_offset;
	assign cmd.block_is_null = req.block_is_null;

	// A finished result moves on when the output register is free or draining.
	assign ack = stat.done && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (ack)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack)
			rsp_q <= rslt;
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.result_offset = rsp_q.result_offset;
	assign rsp.result_null   = rsp_q.result_null;

	sfla_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.ack    (ack),
		.stat   (stat),
		.rslt   (rslt),
		.mem    (mem),
		.rdata  (rdata)
	);

	sfla_ram #(
		.WIDTH (WORD_W),
		.DEPTH (HEAP_WORDS)
	) u_heap (
		.clk     (clk),
		.wr_en   (mem.we),
		.wr_addr (mem.wa),
		.wr_data (mem.wd),
		.rd_en   (mem.re),
		.rd_addr (mem.ra),
		.rd_data (rdata)
	);
endmodule

// ----- hw/rtl/sfla_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module sfla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write statement first in program order; a read of the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end
endmodule

// ----- hw/rtl/sfla_seq.sv -----
// Sequencer that runs the allocator routines as read-modify-write steps on heap memory.
`timescale 1ns / 1ps
module sfla_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  sfla_pkg::cmd_t          cmd,
	input  logic                    ack,
	output sfla_pkg::seq_stat_t     stat,
	output sfla_pkg::rslt_t         rslt,
	output sfla_pkg::mem_req_t      mem,
	input  logic [sfla_pkg::WORD_W-1:0] rdata
);
	import sfla_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE, S_DONE,
		S_I0, S_I1, S_I2, S_I3, S_I4, S_I5,
		S_A0, S_AGR, S_F0, S_F1, S_F2, S_F3, S_F4,
		S_G0, S_G1, S_G2, S_G3, S_G4,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P9, S_PEND,
		S_R0, S_R1, S_R2, S_R3, S_R4,
		S_X0, S_X1, S_X2, S_X3, S_X4,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
		S_MA1, S_MA2, S_MA3, S_MA4,
		S_MB1, S_MB2, S_MB3, S_MB4,
		S_MC0, S_MC1, S_MC2, S_MC3, S_MC4, S_MC5,
		S_L0, S_L1, S_L2, S_L3, S_L4, S_L5,
		S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6
	} state_t;

	state_t st_q, u_ret_q, m_ret_q, g_ret_q;

	logic [BRK_W-1:0]  brk_q;
	logic              ok_q, resize_q, oob_q, pa_q;
	logic [15:0]       res_q, req_q, off_q;
	logic [31:0]       mbp_q, ubp_q, h_q, p_q, s_q;
	logic [31:0]       orig_q, size_q, prev_q, next_q, nsz_q;
	logic [31:0]       gsz_q, gbp_q, pbp_q, asize_q, csize_q, abp_q, fbp_q, os_q;
	logic [CLS_W-1:0]  cls_q;
	logic [STEP_W-1:0] steps_q, cnt_q, n_q;

	logic        re, we;
	logic [31:0] ra, wa, wd;
	logic [31:0] rdv, szv, prev_d, asz_d, gb_d, c_d, n_d, off32, brk32;

	// Read data of an address outside the store is zero.
	assign rdv    = oob_q ? 32'd0 : rdata;
	assign szv    = sz(rdv);
	assign prev_d = mbp_q - szv;
	assign off32  = {16'd0, off_q};
	assign brk32  = {{(32 - BRK_W){1'b0}}, brk_q};
	assign asz_d  = (req_q <= 16'd8) ? 32'd16 : (({16'd0, req_q} + 32'd15) & ~32'd7);
	assign gb_d   = (asize_q > 32'(CHUNK_BYTES)) ? asize_q : 32'(CHUNK_BYTES);
	assign c_d    = (os_q < szv) ? os_q : szv;
	assign n_d    = (c_d >= 32'd8) ? ((c_d - 32'd8) >> 2) : 32'd0;

	// Memory access of the current step.
	always_comb begin
		re = 1'b0;
		we = 1'b0;
		ra = '0;
		wa = '0;
		wd = '0;
		case (st_q)
			S_I0: begin we = 1'b1; wa = 32'd0; wd = 32'd0; end
			S_I1: begin
				we = 1'b1; wa = head_addr(cnt_q[CLS_W-1:0]); wd = 32'd0;
			end
			S_I2: begin we = 1'b1; wa = BASE_OFF + 32'd4;  wd = 32'd9; end
			S_I3: begin we = 1'b1; wa = BASE_OFF + 32'd8;  wd = 32'd9; end
			S_I4: begin we = 1'b1; wa = BASE_OFF + 32'd12; wd = 32'd1; end
			S_F0: begin re = (cls_q < CLS_W'(SIZE_CLASSES)); ra = head_addr(cls_q); end
			S_F2: begin
				re = (fbp_q != 32'd0) && (steps_q < STEP_W'(HEAP_WORDS));
				ra = fbp_q - 32'd4;
			end
			S_F3: begin re = (szv < asize_q); ra = fbp_q + 32'd4; end
			S_G0: begin
				we = (gsz_q <= 32'(HEAP_BYTES) - brk32);
				wa = brk32 - 32'd4; wd = gsz_q;
			end
			S_G1: begin we = 1'b1; wa = gbp_q + gsz_q - 32'd8; wd = gsz_q; end
			S_G2: begin we = 1'b1; wa = gbp_q; wd = 32'd0; end
			S_G3: begin we = 1'b1; wa = gbp_q + 32'd4; wd = 32'd0; end
			S_G4: begin we = 1'b1; wa = gbp_q + gsz_q - 32'd4; wd = 32'd1; end
			S_P0: begin re = 1'b1; ra = pbp_q - 32'd4; end
			S_P2: begin
				we = 1'b1; wa = pbp_q - 32'd4;
				wd = (csize_q >= asize_q && csize_q - asize_q >= 32'd16) ?
					(asize_q | 32'd1) : (csize_q | 32'd1);
			end
			S_P3: begin we = 1'b1; wa = pbp_q + asize_q - 32'd8; wd = asize_q | 32'd1; end
			S_P4: begin we = 1'b1; wa = pbp_q + asize_q - 32'd4; wd = csize_q - asize_q; end
			S_P5: begin
				we = 1'b1; wa = pbp_q + csize_q - 32'd8; wd = csize_q - asize_q;
			end
			S_P6: begin we = 1'b1; wa = pbp_q + asize_q; wd = 32'd0; end
			S_P7: begin we = 1'b1; wa = pbp_q + asize_q + 32'd4; wd = 32'd0; end
			S_P9: begin we = 1'b1; wa = pbp_q + csize_q - 32'd8; wd = csize_q | 32'd1; end
			S_R0: begin re = 1'b1; ra = mbp_q - 32'd4; end
			S_R1: begin we = 1'b1; wa = mbp_q - 32'd4; wd = szv; end
			S_R2: begin we = 1'b1; wa = mbp_q + size_q - 32'd8; wd = size_q; end
			S_R3: begin we = 1'b1; wa = mbp_q; wd = 32'd0; end
			S_R4: begin we = 1'b1; wa = mbp_q + 32'd4; wd = 32'd0; end
			S_X0: begin re = 1'b1; ra = off32 - 32'd4; end
			S_X1: begin re = 1'b1; ra = abp_q - 32'd4; end
			S_X3: begin
				re = (cnt_q < n_q);
				ra = off32 + {{(30 - STEP_W){1'b0}}, cnt_q, 2'b00};
			end
			S_X4: begin
				we = 1'b1; wa = abp_q + {{(30 - STEP_W){1'b0}}, cnt_q, 2'b00}; wd = rdv;
			end
			S_M0: begin re = 1'b1; ra = mbp_q - 32'd4; end
			S_M1: begin re = 1'b1; ra = mbp_q - 32'd8; end
			S_M2: begin re = 1'b1; ra = prev_d - 32'd4; end
			S_M3: begin re = 1'b1; ra = prev_q + szv - 32'd8; end
			S_M4: begin re = 1'b1; ra = next_q - 32'd4; end
			S_MA1: begin re = 1'b1; ra = next_q - 32'd4; end
			S_MA3: begin we = 1'b1; wa = mbp_q - 32'd4; wd = size_q; end
			S_MA4: begin we = 1'b1; wa = mbp_q + size_q - 32'd8; wd = size_q; end
			S_MB1: begin re = 1'b1; ra = prev_q - 32'd4; end
			S_MB3: begin we = 1'b1; wa = mbp_q + orig_q - 32'd8; wd = size_q; end
			S_MB4: begin we = 1'b1; wa = prev_q - 32'd4; wd = size_q; end
			S_MC1: begin re = 1'b1; ra = next_q - 32'd4; end
			S_MC2: begin re = 1'b1; ra = prev_q - 32'd4; end
			S_MC4: begin we = 1'b1; wa = prev_q - 32'd4; wd = size_q; end
			S_MC5: begin we = 1'b1; wa = next_q + nsz_q - 32'd8; wd = size_q; end
			S_L0: begin re = 1'b1; ra = mbp_q - 32'd4; end
			S_L1: begin re = 1'b1; ra = head_addr(class_of(szv)); end
			S_L2: begin we = 1'b1; wa = mbp_q; wd = 32'd0; end
			S_L3: begin we = 1'b1; wa = mbp_q + 32'd4; wd = s_q; end
			S_L4: begin we = (s_q != 32'd0); wa = s_q; wd = mbp_q; end
			S_L5: begin we = 1'b1; wa = h_q; wd = mbp_q; end
			S_U0: begin re = 1'b1; ra = ubp_q - 32'd4; end
			S_U1: begin re = 1'b1; ra = ubp_q; end
			S_U2: begin re = 1'b1; ra = ubp_q + 32'd4; end
			S_U3: begin
				we = 1'b1; wa = (p_q == 32'd0) ? h_q : (p_q + 32'd4); wd = rdv;
			end
			S_U4: begin we = (s_q != 32'd0); wa = s_q; wd = p_q; end
			S_U5: begin we = 1'b1; wa = ubp_q; wd = 32'd0; end
			S_U6: begin we = 1'b1; wa = ubp_q + 32'd4; wd = 32'd0; end
			default: ;
		endcase
	end

	// Accesses outside the store are dropped on write and read as zero.
	assign mem.re = re && in_heap(ra);
	assign mem.ra = ra[ADDR_W+1:2];
	assign mem.we = we && in_heap(wa);
	assign mem.wa = wa[ADDR_W+1:2];
	assign mem.wd = wd;

	assign stat.idle          = (st_q == S_IDLE);
	assign stat.done          = (st_q == S_DONE);
	assign rslt.result_offset = res_q;
	assign rslt.result_null   = !ok_q;

	// Step sequencing and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			brk_q <= '0;
			ok_q  <= 1'b0;
			oob_q <= 1'b0;
		end else begin
			if (re)
				oob_q <= !in_heap(ra);
			case (st_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= cmd.request_size;
						off_q    <= cmd.block_offset;
						res_q    <= '0;
						ok_q     <= 1'b0;
						resize_q <= (cmd.action == ACT_RESIZE) && !cmd.block_is_null;
						if (cmd.action == ACT_INIT)
							st_q <= S_I0;
						else if (brk_q == '0)
							st_q <= S_DONE;
						else if (cmd.action == ACT_ALLOC ||
								(cmd.action == ACT_RESIZE && cmd.block_is_null))
							st_q <= S_A0;
						else if (cmd.action == ACT_RELEASE) begin
							mbp_q <= {16'd0, cmd.block_offset};
							st_q  <= cmd.block_is_null ? S_DONE : S_R0;
						end else
							st_q <= S_A0;
					end
				end
				S_DONE: if (ack) st_q <= S_IDLE;
				// Init: pad word, class heads, prologue, epilogue, first chunk.
				S_I0: begin brk_q <= '0; cnt_q <= '0; st_q <= S_I1; end
				S_I1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(SIZE_CLASSES - 1))
						st_q <= S_I2;
				end
				S_I2: st_q <= S_I3;
				S_I3: st_q <= S_I4;
				S_I4: begin
					brk_q   <= BRK_W'(BASE_OFF + 32'd16);
					gsz_q   <= grow_size(32'(CHUNK_BYTES));
					g_ret_q <= S_I5;
					st_q    <= S_G0;
				end
				S_I5: begin
					if (mbp_q == 32'd0) begin
						brk_q <= '0;
						ok_q  <= 1'b0;
					end else
						ok_q <= 1'b1;
					st_q <= S_DONE;
				end
				// Allocate: size rounding and first-fit search over classes.
				S_A0: begin
					if (req_q == 16'd0)
						st_q <= S_DONE;
					else begin
						asize_q <= asz_d;
						cls_q   <= class_of(asz_d);
						steps_q <= '0;
						st_q    <= S_F0;
					end
				end
				S_F0: begin
					if (cls_q >= CLS_W'(SIZE_CLASSES)) begin
						gsz_q   <= grow_size(gb_d);
						g_ret_q <= S_AGR;
						st_q    <= S_G0;
					end else
						st_q <= S_F1;
				end
				S_F1: begin fbp_q <= rdv; st_q <= S_F2; end
				S_F2: begin
					if (fbp_q != 32'd0 && steps_q < STEP_W'(HEAP_WORDS))
						st_q <= S_F3;
					else begin
						cls_q <= cls_q + 1'b1;
						st_q  <= S_F0;
					end
				end
				S_F3: begin
					if (szv >= asize_q) begin
						pbp_q <= fbp_q;
						st_q  <= S_P0;
					end else
						st_q <= S_F4;
				end
				S_F4: begin fbp_q <= rdv; steps_q <= steps_q + 1'b1; st_q <= S_F2; end
				S_AGR: begin
					if (mbp_q == 32'd0)
						st_q <= S_DONE;
					else begin
						pbp_q <= mbp_q;
						st_q  <= S_P0;
					end
				end
				// Grow: extend the break and merge the new block.
				S_G0: begin
					if (gsz_q > 32'(HEAP_BYTES) - brk32) begin
						mbp_q <= 32'd0;
						st_q  <= g_ret_q;
					end else begin
						gbp_q <= brk32;
						brk_q <= BRK_W'(brk32 + gsz_q);
						st_q  <= S_G1;
					end
				end
				S_G1: st_q <= S_G2;
				S_G2: st_q <= S_G3;
				S_G3: st_q <= S_G4;
				S_G4: begin mbp_q <= gbp_q; m_ret_q <= g_ret_q; st_q <= S_M0; end
				// Place: unlink, then split off a large remainder.
				S_P0: st_q <= S_P1;
				S_P1: begin
					csize_q <= szv;
					ubp_q   <= pbp_q;
					u_ret_q <= S_P2;
					st_q    <= S_U0;
				end
				S_P2: st_q <= (csize_q >= asize_q && csize_q - asize_q >= 32'd16) ?
					S_P3 : S_P9;
				S_P3: st_q <= S_P4;
				S_P4: st_q <= S_P5;
				S_P5: st_q <= S_P6;
				S_P6: st_q <= S_P7;
				S_P7: begin
					mbp_q   <= pbp_q + asize_q;
					m_ret_q <= S_PEND;
					st_q    <= S_M0;
				end
				S_P9: st_q <= S_PEND;
				S_PEND: begin
					abp_q <= pbp_q;
					if (resize_q)
						st_q <= S_X0;
					else begin
						res_q <= pbp_q[15:0];
						ok_q  <= 1'b1;
						st_q  <= S_DONE;
					end
				end
				// Release: clear the allocated bit and merge.
				S_R0: st_q <= S_R1;
				S_R1: begin size_q <= szv; st_q <= S_R2; end
				S_R2: st_q <= S_R3;
				S_R3: st_q <= S_R4;
				S_R4: begin m_ret_q <= S_DONE; st_q <= S_M0; end
				// Resize: copy the smaller payload, then release the old block.
				S_X0: st_q <= S_X1;
				S_X1: begin os_q <= szv; st_q <= S_X2; end
				S_X2: begin
					n_q   <= (n_d > 32'(HEAP_WORDS)) ? STEP_W'(HEAP_WORDS) : n_d[STEP_W-1:0];
					cnt_q <= '0;
					st_q  <= S_X3;
				end
				S_X3: begin
					if (cnt_q < n_q)
						st_q <= S_X4;
					else begin
						mbp_q <= off32;
						res_q <= abp_q[15:0];
						ok_q  <= 1'b1;
						st_q  <= S_R0;
					end
				end
				S_X4: begin cnt_q <= cnt_q + 1'b1; st_q <= S_X3; end
				// Merge: look at both neighbors and pick a coalescing case.
				S_M0: st_q <= S_M1;
				S_M1: begin
					orig_q <= szv;
					size_q <= szv;
					next_q <= mbp_q + szv;
					st_q   <= S_M2;
				end
				S_M2: begin prev_q <= prev_d; st_q <= S_M3; end
				S_M3: st_q <= S_M4;
				S_M4: begin pa_q <= rdv[0]; st_q <= S_M5; end
				S_M5: begin
					if (pa_q && rdv[0])
						st_q <= S_L0;
					else if (pa_q) begin
						ubp_q <= next_q; u_ret_q <= S_MA1; st_q <= S_U0;
					end else if (rdv[0]) begin
						ubp_q <= prev_q; u_ret_q <= S_MB1; st_q <= S_U0;
					end else begin
						ubp_q <= next_q; u_ret_q <= S_MC0; st_q <= S_U0;
					end
				end
				S_MA1: st_q <= S_MA2;
				S_MA2: begin size_q <= size_q + szv; st_q <= S_MA3; end
				S_MA3: st_q <= S_MA4;
				S_MA4: st_q <= S_L0;
				S_MB1: st_q <= S_MB2;
				S_MB2: begin size_q <= size_q + szv; st_q <= S_MB3; end
				S_MB3: st_q <= S_MB4;
				S_MB4: begin mbp_q <= prev_q; st_q <= S_L0; end
				S_MC0: begin ubp_q <= prev_q; u_ret_q <= S_MC1; st_q <= S_U0; end
				S_MC1: st_q <= S_MC2;
				S_MC2: begin nsz_q <= szv; st_q <= S_MC3; end
				S_MC3: begin size_q <= size_q + szv + nsz_q; st_q <= S_MC4; end
				S_MC4: st_q <= S_MC5;
				S_MC5: begin mbp_q <= prev_q; st_q <= S_L0; end
				// Link in: push the block at the head of its class list.
				S_L0: st_q <= S_L1;
				S_L1: begin h_q <= head_addr(class_of(szv)); st_q <= S_L2; end
				S_L2: begin s_q <= rdv; st_q <= S_L3; end
				S_L3: st_q <= S_L4;
				S_L4: st_q <= S_L5;
				S_L5: st_q <= m_ret_q;
				// Unlink: splice the block out of its class list.
				S_U0: st_q <= S_U1;
				S_U1: begin h_q <= head_addr(class_of(szv)); st_q <= S_U2; end
				S_U2: begin p_q <= rdv; st_q <= S_U3; end
				S_U3: begin s_q <= rdv; st_q <= S_U4; end
				S_U4: st_q <= S_U5;
				S_U5: st_q <= S_U6;
				S_U6: st_q <= u_ret_q;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/sfla_chk.sv -----
// Port-level checker for the allocator top level, with its bind statement.
`timescale 1ns / 1ps
module sfla_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] rsp_offset,
	input logic        rsp_null
);
	logic [1:0] pend_q;

	// Requests taken whose result beat has not yet gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, req_valid && req_ready} -
				{1'b0, rsp_valid && rsp_ready};
		end
	end

	// A result beat always answers an earlier request.
	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result beat without an outstanding request");

	// The block works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	// A null result carries a zero offset.
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_null |-> rsp_offset == 16'd0)
		else $error("null result with a nonzero offset");

	// A stalled result beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset) && $stable(rsp_null))
		else $error("stalled result beat changed");
endmodule

bind segregated_free_list_allocator_top sfla_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_offset (rsp.result_offset),
	.rsp_null   (rsp.result_null)
);

// ----- tb/segregated_free_list_allocator_top_tb.sv -----
// Self-checking testbench for the segregated free-list heap allocator top level.
`timescale 1ns / 1ps
module segregated_free_list_allocator_top_tb;

	localparam int HW        = sfla_pkg::HEAP_WORDS;
	localparam int NCLS      = sfla_pkg::SIZE_CLASSES;
	localparam int CHUNK     = sfla_pkg::CHUNK_BYTES;
	localparam int IDLE_MAX  = 200000;
	localparam int LIVE_CAP  = 60;

	typedef struct {
		sfla_pkg::action_t act;
		logic [15:0]       size;
		logic [15:0]       off;
		logic              is_null;
		logic [15:0]       want_off;
		logic              want_null;
	} heap_req_t;

	typedef struct {
		logic [15:0] off;
		logic        is_null;
	} grant_t;

	logic clk;
	logic arst_n;

	sfla_req_if req ();
	sfla_rsp_if rsp ();

	segregated_free_list_allocator_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	// Shadow heap and its bookkeeping.
	bit [31:0]   shadow_mem [HW];
	bit          shadow_set [HW];
	int unsigned shadow_brk;

	heap_req_t   req_backlog[$];
	grant_t      grants_due[$];
	int unsigned live_blocks[$];
	grant_t      grant_in_flight;

	int          snd_idle_pct;
	int          rcv_stall_pct;
	int          hold_request;
	int          hold_left;
	logic        req_fire;
	int          idle_cycles;
	int          errors;
	int          n_grants;
	int          n_nulls;
	int          n_by_act [4];

	// Shadow heap word access; out-of-range reads give zero, writes are dropped.
	function automatic int unsigned mem_rd(int unsigned a);
		int unsigned i;
		i = a >> 2;
		return (i < HW) ? shadow_mem[i] : 0;
	endfunction

	function automatic void mem_wr(int unsigned a, int unsigned v);
		int unsigned i;
		i = a >> 2;
		if (i < HW) begin
			shadow_mem[i] = v;
			shadow_set[i] = 1'b1;
		end
	endfunction

	function automatic int unsigned tag_size(int unsigned v);
		return v & ~32'd7;
	endfunction

	function automatic int unsigned size_class(int unsigned s);
		for (int unsigned i = 0; i + 1 < NCLS; i++) begin
			if (s < (32'd1 << (i + 5)))
				return i;
		end
		return NCLS - 1;
	endfunction

	function automatic int unsigned list_head(int unsigned c);
		return 4 + c * 4;
	endfunction

	// Push a free block at the head of its class list.
	function automatic void list_push(int unsigned bp);
		int unsigned h, old;
		h = list_head(size_class(tag_size(mem_rd(bp - 4))));
		old = mem_rd(h);
		mem_wr(bp, 0);
		mem_wr(bp + 4, old);
		if (old != 0)
			mem_wr(old, bp);
		mem_wr(h, bp);
	endfunction

	function automatic void list_remove(int unsigned bp);
		int unsigned h, p, s;
		h = list_head(size_class(tag_size(mem_rd(bp - 4))));
		p = mem_rd(bp);
		s = mem_rd(bp + 4);
		if (p == 0)
			mem_wr(h, s);
		else
			mem_wr(p + 4, s);
		if (s != 0)
			mem_wr(s, p);
		mem_wr(bp, 0);
		mem_wr(bp + 4, 0);
	endfunction

	// Boundary-tag coalescing with both neighbors, then list insertion.
	function automatic int unsigned coalesce(int unsigned bp);
		int unsigned orig, size, prv, nxt, pa, na, nsz;
		orig = tag_size(mem_rd(bp - 4));
		size = orig;
		prv = bp - tag_size(mem_rd(bp - 8));
		nxt = bp + orig;
		pa = mem_rd(prv + tag_size(mem_rd(prv - 4)) - 8) & 1;
		na = mem_rd(nxt - 4) & 1;
		if (pa && na) begin
		end else if (pa) begin
			list_remove(nxt);
			size += tag_size(mem_rd(nxt - 4));
			mem_wr(bp - 4, size);
			mem_wr(bp + size - 8, size);
		end else if (na) begin
			list_remove(prv);
			size += tag_size(mem_rd(prv - 4));
			mem_wr(bp + orig - 8, size);
			mem_wr(prv - 4, size);
			bp = prv;
		end else begin
			list_remove(nxt);
			list_remove(prv);
			nsz = tag_size(mem_rd(nxt - 4));
			size += tag_size(mem_rd(prv - 4)) + nsz;
			mem_wr(prv - 4, size);
			mem_wr(nxt + nsz - 8, size);
			bp = prv;
		end
		list_push(bp);
		return bp;
	endfunction

	function automatic int unsigned grow_heap(int unsigned bytes);
		int unsigned words, size, bp;
		words = bytes / 4;
		if (words & 1)
			words++;
		size = words * 4;
		if (size > HW * 4 - shadow_brk)
			return 0;
		bp = shadow_brk;
		shadow_brk += size;
		mem_wr(bp - 4, size);
		mem_wr(bp + size - 8, size);
		mem_wr(bp, 0);
		mem_wr(bp + 4, 0);
		mem_wr(bp + size - 4, 1);
		return coalesce(bp);
	endfunction

	// Mark a block used, splitting off a free tail of 16 bytes or more.
	function automatic void carve(int unsigned bp, int unsigned asize);
		int unsigned csize, nb;
		csize = tag_size(mem_rd(bp - 4));
		list_remove(bp);
		if (csize >= asize && csize - asize >= 16) begin
			nb = bp + asize;
			mem_wr(bp - 4, asize | 1);
			mem_wr(bp + asize - 8, asize | 1);
			mem_wr(nb - 4, csize - asize);
			mem_wr(nb + (csize - asize) - 8, csize - asize);
			mem_wr(nb, 0);
			mem_wr(nb + 4, 0);
			void'(coalesce(nb));
		end else begin
			mem_wr(bp - 4, csize | 1);
			mem_wr(bp + csize - 8, csize | 1);
		end
	endfunction

	function automatic int unsigned first_fit(int unsigned asize);
		int unsigned bp, steps;
		steps = 0;
		for (int unsigned c = size_class(asize); c < NCLS; c++) begin
			bp = mem_rd(list_head(c));
			while (bp != 0 && steps < HW) begin
				if (tag_size(mem_rd(bp - 4)) >= asize)
					return bp;
				bp = mem_rd(bp + 4);
				steps++;
			end
		end
		return 0;
	endfunction

	function automatic int unsigned heap_alloc(int unsigned size);
		int unsigned asize, bp;
		if (size == 0)
			return 0;
		asize = (size <= 8) ? 16 : 8 * ((size + 15) / 8);
		bp = first_fit(asize);
		if (bp == 0) begin
			bp = grow_heap((asize > CHUNK) ? asize : CHUNK);
			if (bp == 0)
				return 0;
		end
		carve(bp, asize);
		return bp;
	endfunction

	function automatic void heap_free(int unsigned bp);
		int unsigned size;
		size = tag_size(mem_rd(bp - 4));
		mem_wr(bp - 4, size);
		mem_wr(bp + size - 8, size);
		mem_wr(bp, 0);
		mem_wr(bp + 4, 0);
		void'(coalesce(bp));
	endfunction

	function automatic bit heap_init();
		int unsigned base;
		base = 4 * NCLS;
		shadow_brk = 0;
		if (base + 16 > HW * 4)
			return 0;
		mem_wr(0, 0);
		for (int unsigned i = 0; i < NCLS; i++)
			mem_wr(list_head(i), 0);
		mem_wr(base + 4, 8 | 1);
		mem_wr(base + 8, 8 | 1);
		mem_wr(base + 12, 1);
		shadow_brk = base + 16;
		if (grow_heap(CHUNK) == 0) begin
			shadow_brk = 0;
			return 0;
		end
		return 1;
	endfunction

	// True when a resize of this block copies only words that hold known data.
	function automatic bit copy_known(int unsigned off);
		int unsigned os, n, w;
		os = tag_size(mem_rd(off - 4));
		n = (os >= 8) ? (os - 8) / 4 : 0;
		for (int unsigned i = 0; i < n; i++) begin
			w = (off >> 2) + i;
			if (w < HW && !shadow_set[w])
				return 0;
		end
		return 1;
	endfunction

	// Work out the grant of one request and advance the shadow heap.
	function automatic void predict_grant(ref heap_req_t it);
		int unsigned res, nb, os, ns, c, n;
		bit ok;
		res = 0;
		ok = 0;
		if (it.act == sfla_pkg::ACT_INIT) begin
			ok = heap_init();
		end else if (shadow_brk != 0) begin
			if (it.act == sfla_pkg::ACT_ALLOC ||
				(it.act == sfla_pkg::ACT_RESIZE && it.is_null)) begin
				res = heap_alloc(it.size);
				ok = res != 0;
			end else if (it.act == sfla_pkg::ACT_RELEASE) begin
				if (!it.is_null)
					heap_free(it.off);
			end else begin
				nb = heap_alloc(it.size);
				if (nb != 0) begin
					os = tag_size(mem_rd(it.off - 4));
					ns = tag_size(mem_rd(nb - 4));
					c = (os < ns) ? os : ns;
					n = (c >= 8) ? (c - 8) / 4 : 0;
					if (n > HW)
						n = HW;
					for (int unsigned i = 0; i < n; i++)
						mem_wr(nb + 4 * i, mem_rd(it.off + 4 * i));
					heap_free(it.off);
					res = nb;
					ok = 1;
				end
			end
		end
		if (it.act != sfla_pkg::ACT_INIT && !ok)
			res = 0;
		it.want_off = res[15:0];
		it.want_null = !ok;
	endfunction

	// Predict one request, queue it and keep the list of held blocks current.
	task automatic issue(input sfla_pkg::action_t act, input int unsigned size,
		input int unsigned off, input bit is_null);
		heap_req_t it;
		it.act = act;
		it.size = size[15:0];
		it.off = off[15:0];
		it.is_null = is_null;
		predict_grant(it);
		if (act == sfla_pkg::ACT_INIT) begin
			live_blocks.delete();
		end else if (act == sfla_pkg::ACT_RELEASE && !is_null) begin
			foreach (live_blocks[i])
				if (live_blocks[i] == off) begin
					live_blocks.delete(i);
					break;
				end
		end else if (act == sfla_pkg::ACT_RESIZE && !is_null && !it.want_null) begin
			foreach (live_blocks[i])
				if (live_blocks[i] == off) begin
					live_blocks.delete(i);
					break;
				end
		end
		if (act != sfla_pkg::ACT_INIT && act != sfla_pkg::ACT_RELEASE && !it.want_null)
			live_blocks.push_back(it.want_off);
		req_backlog.push_back(it);
	endtask

	function automatic int unsigned pick_size();
		int p;
		p = $urandom_range(99);
		if (p < 50)
			return $urandom_range(8, 1);
		else if (p < 85)
			return $urandom_range(256, 9);
		else if (p < 97)
			return $urandom_range(4096, 257);
		return $urandom_range(20000, 4097);
	endfunction

	// Release or resize a held block, choosing resize only when its copy is safe.
	task automatic touch_live(input bit want_resize);
		int idx;
		int unsigned bp;
		idx = $urandom_range(live_blocks.size() - 1);
		bp = live_blocks[idx];
		if (want_resize && copy_known(bp))
			issue(sfla_pkg::ACT_RESIZE, pick_size(), bp, 1'b0);
		else
			issue(sfla_pkg::ACT_RELEASE, $urandom_range(16'hffff), bp, 1'b0);
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (live_blocks.size() > LIVE_CAP)
			touch_live(1'b0);
		else if (r < 2)
			issue(sfla_pkg::ACT_INIT, $urandom_range(16'hffff), $urandom_range(16'hffff),
				$urandom_range(1));
		else if (r < 45 || (r < 93 && live_blocks.size() == 0))
			issue(sfla_pkg::ACT_ALLOC, pick_size(), $urandom_range(16'hffff),
				$urandom_range(1));
		else if (r < 78)
			touch_live(1'b0);
		else if (r < 93)
			touch_live(1'b1);
		else if (r < 96)
			issue($urandom_range(1) ? sfla_pkg::ACT_RELEASE : sfla_pkg::ACT_RESIZE,
				pick_size(), $urandom_range(16'hffff), 1'b1);
		else
			issue(sfla_pkg::ACT_ALLOC, $urandom_range(1) ? 0 : $urandom_range(16'hffff, 60000),
				$urandom_range(16'hffff), $urandom_range(1));
	endtask

	// Hold off new requests until every grant has come back.
	task automatic drain();
		while (req_backlog.size() != 0 || req.valid || grants_due.size() != 0)
			@(posedge clk);
	endtask

	// Clock and reset.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = '0;
		req.request_size = '0;
		req.block_offset = '0;
		req.block_is_null = 1'b0;
		rsp.ready = 1'b0;
		repeat (5) begin
			#2 clk = 1'b1;
			#2 clk = 1'b0;
		end
		arst_n = 1'b1;
		forever #2 clk = ~clk;
	end

	// Request driver: holds a beat until it is taken, then offers the next one.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req.valid && !req_fire) begin
			end else if (req_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				req.valid <= 1'b1;
				req.action <= req_backlog[0].act;
				req.request_size <= req_backlog[0].size;
				req.block_offset <= req_backlog[0].off;
				req.block_is_null <= req_backlog[0].is_null;
				grant_in_flight <= '{req_backlog[0].want_off, req_backlog[0].want_null};
				void'(req_backlog.pop_front());
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus an occasional long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= $urandom_range(99) >= rcv_stall_pct;
			end
		end
	end

	// Monitor: record accepted requests and check every result beat.
	always @(posedge clk) begin
		req_fire <= req.valid && req.ready;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				grants_due.push_back(grant_in_flight);
				n_by_act[req.action]++;
			end
			if (rsp.valid && rsp.ready) begin
				if (grants_due.size() == 0) begin
					$display("%0t: result beat with nothing expected: off=%h null=%b",
						$realtime, rsp.result_offset, rsp.result_null);
					errors++;
				end else begin
					if (rsp.result_offset !== grants_due[0].off ||
						rsp.result_null !== grants_due[0].is_null) begin
						$display("%0t: mismatch: expected off=%h null=%b, got off=%h null=%b",
							$realtime, grants_due[0].off, grants_due[0].is_null,
							rsp.result_offset, rsp.result_null);
						errors++;
					end
					if (rsp.result_null)
						n_nulls++;
					else
						n_grants++;
					void'(grants_due.pop_front());
				end
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("%0t: no beat for %0d cycles", $realtime, idle_cycles);
				$display("segregated_free_list_allocator_top_tb: FAIL");
				$finish;
			end
		end
	end

	// Stimulus: a directed pass, then random phases under different idling.
	initial begin
		int unsigned a, b, c, d;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		req_fire = 1'b0;
		idle_cycles = 0;
		errors = 0;
		n_grants = 0;
		n_nulls = 0;
		n_by_act = '{default: 0};
		shadow_brk = 0;
		foreach (shadow_mem[i]) begin
			shadow_mem[i] = '0;
			shadow_set[i] = 1'b0;
		end
		@(posedge arst_n);

		// Before init everything answers null.
		issue(sfla_pkg::ACT_ALLOC, 16, 16'hffff, 1'b1);
		issue(sfla_pkg::ACT_RELEASE, 16'hffff, 16'h1234, 1'b0);
		issue(sfla_pkg::ACT_RESIZE, 32, 16'h0040, 1'b0);
		issue(sfla_pkg::ACT_INIT, 16'hffff, 16'hffff, 1'b1);
		// Zero size, minimum block, rounding edges, heap full, explicit growth.
		issue(sfla_pkg::ACT_ALLOC, 0, 0, 1'b0);
		issue(sfla_pkg::ACT_ALLOC, 1, 0, 1'b0);
		a = live_blocks[$];
		issue(sfla_pkg::ACT_ALLOC, 8, 0, 1'b0);
		b = live_blocks[$];
		issue(sfla_pkg::ACT_ALLOC, 9, 0, 1'b0);
		c = live_blocks[$];
		issue(sfla_pkg::ACT_ALLOC, 16'hffff, 16'hffff, 1'b1);
		issue(sfla_pkg::ACT_ALLOC, 5000, 0, 1'b0);
		d = live_blocks[$];
		// Null pointer: release is a no-op, resize allocates.
		issue(sfla_pkg::ACT_RELEASE, 0, 16'hffff, 1'b1);
		issue(sfla_pkg::ACT_RESIZE, 8, 16'hffff, 1'b1);
		// Resize to zero keeps the block; a real resize copies and moves it.
		issue(sfla_pkg::ACT_RESIZE, 0, a, 1'b0);
		issue(sfla_pkg::ACT_RESIZE, 200, a, 1'b0);
		issue(sfla_pkg::ACT_RESIZE, 16'hffff, b, 1'b0);
		// Coalescing: lone, next free, previous free, both free.
		issue(sfla_pkg::ACT_RELEASE, 0, c, 1'b0);
		issue(sfla_pkg::ACT_RELEASE, 0, b, 1'b0);
		issue(sfla_pkg::ACT_RELEASE, 0, d, 1'b0);
		while (live_blocks.size() != 0)
			issue(sfla_pkg::ACT_RELEASE, 0, live_blocks[0], 1'b0);
		// Re-init drops everything held.
		issue(sfla_pkg::ACT_ALLOC, 40, 0, 1'b0);
		issue(sfla_pkg::ACT_INIT, 0, 0, 1'b0);
		issue(sfla_pkg::ACT_ALLOC, 40, 0, 1'b0);
		drain();

		// No idling, with one long receiver hold-off while requests keep coming.
		hold_request = 400;
		repeat (400) random_item();
		drain();
		snd_idle_pct = 51;
		repeat (400) random_item();
		drain();
		snd_idle_pct = 0;
		rcv_stall_pct = 51;
		repeat (400) random_item();
		drain();
		snd_idle_pct = 12;
		rcv_stall_pct = 12;
		repeat (400) random_item();
		drain();
		repeat (100) @(posedge clk);

		$display("Covered %0d init, %0d allocate, %0d release, %0d resize requests;",
			n_by_act[0], n_by_act[1], n_by_act[2], n_by_act[3]);
		$display("%0d blocks granted, %0d null answers, %0d mismatches.",
			n_grants, n_nulls, errors);
		if (errors == 0 && grants_due.size() == 0) begin
			$display("segregated_free_list_allocator_top_tb: PASS");
		end else begin
			$display("segregated_free_list_allocator_top_tb: FAIL");
		end
		$finish;
	end

endmodule
